// ----- hdl/hierarchical_zone_profiler_unit_assert.svh -----
// Assertion macros for the zone profiler checker.
`ifndef HIERARCHICAL_ZONE_PROFILER_UNIT_ASSERT_SVH
`define HIERARCHICAL_ZONE_PROFILER_UNIT_ASSERT_SVH

// same-cycle implication
`define HZP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("hzp check failed");

// next-cycle implication
`define HZP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("hzp check failed");

`endif

// ----- hdl/hzp_pkg.sv -----
// Types and codes shared by the zone profiler files.
`default_nettype none

package hzp_pkg;

  localparam int unsigned CNT_W = 64;

  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_END   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_OVF = 2'd1;
  localparam logic [1:0] STAT_UNF = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_END1,
    ST_END2
  } state_e;

  typedef struct packed {
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] excl;
    logic [CNT_W-1:0] incl;
    logic [CNT_W-1:0] bytes;
  } row_t;

endpackage

`default_nettype wire

// ----- hdl/hierarchical_zone_profiler_unit.sv -----
// Hierarchical zone profiler: zone table memory, open-zone stack memory, control.
// Begin, read, overflow and underflow words: result in the cycle after accept.
// End words: result in ST_END2, after ST_END1. A new word waits for the last result.
// The zone table's single read port fetches the zone row and then the parent row.
// After reset a clearing pass zeroes the zone table, busy held high.
// Results are not flow controlled: done_o marks each for exactly one cycle.
`default_nettype none

module hierarchical_zone_profiler_unit
  import hzp_pkg::*;
#(
  parameter int unsigned ZONE_COUNT  = 64,
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [5:0]  zone_i,
  input  wire logic [31:0] byte_count_i,
  input  wire logic [63:0] timestamp_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [5:0]       zone_out_o,
  output logic [63:0]      hits_o,
  output logic [63:0]      exclusive_ticks_o,
  output logic [63:0]      inclusive_ticks_o,
  output logic [63:0]      bytes_total_o
);

  localparam int unsigned ZW  = $clog2(ZONE_COUNT);
  localparam int unsigned SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned LVW = $clog2(STACK_DEPTH + 1);

  typedef struct packed {
    logic [ZW-1:0]    zone;
    logic [ZW-1:0]    parent;
    logic [CNT_W-1:0] old_incl;
    logic [CNT_W-1:0] start;
  } stk_ent_t;

  // zone index reduction table
  logic [ZW-1:0] zmod_tab [64];
  for (genvar g = 0; g < 64; g++) begin : g_zmod
    assign zmod_tab[g] = ZW'(g % ZONE_COUNT);
  end

  state_e           state_q, state_d;
  logic [ZW-1:0]    clr_q, clr_d;
  logic [ZW-1:0]    parent_q, parent_d;
  logic [LVW-1:0]   level_q, level_d;
  logic [1:0]       cmd_q, cmd_d;
  logic [ZW-1:0]    zone_q, zone_d;
  logic [ZW-1:0]    pz_q, pz_d;
  logic [31:0]      bytes_q, bytes_d;
  logic [CNT_W-1:0] ts_q, ts_d;
  logic [CNT_W-1:0] elapsed_q, elapsed_d;
  row_t             upd_q, upd_d;

  row_t             zmem [ZONE_COUNT];
  row_t             row_rd_q;
  logic             z_we;
  logic [ZW-1:0]    z_wa, z_ra;
  row_t             z_wd;

  stk_ent_t         smem [STACK_DEPTH];
  stk_ent_t         stk_rd_q;
  logic             s_we;
  logic [SAW-1:0]   s_wa, s_ra;
  stk_ent_t         s_wd;
  logic [LVW-1:0]   lvl_dec;

  logic [ZW-1:0]    zsel;
  row_t             row_new, base_row;
  row_t             out_row;
  logic [ZW-1:0]    out_zone;
  logic [ZW+5:0]    zo_ext;

  assign zsel    = zmod_tab[zone_i];
  assign lvl_dec = level_q - 1'b1;
  assign s_ra    = lvl_dec[SAW-1:0];
  assign s_wa    = level_q[SAW-1:0];
  assign busy    = (state_q != ST_IDLE);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    parent_d  = parent_q;
    level_d   = level_q;
    cmd_d     = cmd_q;
    zone_d    = zone_q;
    pz_d      = pz_q;
    bytes_d   = bytes_q;
    ts_d      = ts_q;
    elapsed_d = elapsed_q;
    upd_d     = upd_q;
    z_we      = 1'b0;
    z_wa      = zone_q;
    z_wd      = row_rd_q;
    s_we      = 1'b0;
    s_wd      = '{zone: zone_q, parent: parent_q, old_incl: row_rd_q.incl, start: ts_q};
    z_ra      = (cmd_i == CMD_END) ? parent_q : zsel;
    row_new   = row_rd_q;
    base_row  = row_rd_q;
    done_o    = 1'b0;
    status_o  = STAT_OK;
    out_row   = row_rd_q;
    out_zone  = zone_q;
    case (state_q)
      ST_CLEAR: begin
        z_we  = 1'b1;
        z_wa  = clr_q;
        z_wd  = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == ZW'(ZONE_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_d   = cmd_i;
          zone_d  = zsel;
          bytes_d = byte_count_i;
          ts_d    = timestamp_i;
          state_d = (cmd_i == CMD_END && level_q != '0) ? ST_END1 : ST_EXEC;
        end
      end
      ST_EXEC: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
        if (cmd_q == CMD_END) begin
          status_o = STAT_UNF;
          out_row  = '0;
          out_zone = '0;
        end else if (cmd_q == CMD_BEGIN) begin
          if (level_q == LVW'(STACK_DEPTH)) begin
            status_o = STAT_OVF;
          end else begin
            row_new.bytes = row_rd_q.bytes + {32'b0, bytes_q};
            z_we     = 1'b1;
            z_wd     = row_new;
            s_we     = 1'b1;
            parent_d = zone_q;
            level_d  = level_q + 1'b1;
            out_row  = row_new;
          end
        end
      end
      ST_END1: begin
        elapsed_d    = ts_q - stk_rd_q.start;
        row_new.hits = row_rd_q.hits + 1'b1;
        row_new.excl = row_rd_q.excl + elapsed_d;
        row_new.incl = stk_rd_q.old_incl + elapsed_d;
        z_we     = 1'b1;
        z_wa     = stk_rd_q.zone;
        z_wd     = row_new;
        upd_d    = row_new;
        z_ra     = stk_rd_q.parent;
        zone_d   = stk_rd_q.zone;
        pz_d     = stk_rd_q.parent;
        parent_d = stk_rd_q.parent;
        level_d  = level_q - 1'b1;
        state_d  = ST_END2;
      end
      ST_END2: begin
        // parent row may be the row just written
        base_row      = (pz_q == zone_q) ? upd_q : row_rd_q;
        row_new       = base_row;
        row_new.excl  = base_row.excl - elapsed_q;
        z_we     = 1'b1;
        z_wa     = pz_q;
        z_wd     = row_new;
        done_o   = 1'b1;
        out_row  = (pz_q == zone_q) ? row_new : upd_q;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign zo_ext            = {6'b0, out_zone};
  assign zone_out_o        = zo_ext[5:0];
  assign hits_o            = out_row.hits;
  assign exclusive_ticks_o = out_row.excl;
  assign inclusive_ticks_o = out_row.incl;
  assign bytes_total_o     = out_row.bytes;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      parent_q <= '0;
      level_q  <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      parent_q <= parent_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    zone_q    <= zone_d;
    pz_q      <= pz_d;
    bytes_q   <= bytes_d;
    ts_q      <= ts_d;
    elapsed_q <= elapsed_d;
    upd_q     <= upd_d;
  end

  always_ff @(posedge clk_i) begin
    if (z_we) begin
      zmem[z_wa] <= z_wd;
    end
    row_rd_q <= zmem[z_ra];
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      smem[s_wa] <= s_wd;
    end
    stk_rd_q <= smem[s_ra];
  end

endmodule

`default_nettype wire

// ----- hdl/hzp_checker.sv -----
// Port-level checks for the zone profiler and their bind.
`default_nettype none

`include "hierarchical_zone_profiler_unit_assert.svh"

module hzp_checker
  import hzp_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_i,
  input wire logic        done_i,
  input wire logic [1:0]  status_i,
  input wire logic [5:0]  zone_out_i,
  input wire logic [63:0] hits_i
);

  logic unf_word;
  logic status_known;

  assign unf_word     = done_i && (status_i == STAT_UNF);
  assign status_known = (status_i == STAT_OK) || (status_i == STAT_OVF) ||
                        (status_i == STAT_UNF);

  `HZP_ASSERT_NOW(a_done_busy, clk_i, rst_ni, done_i, busy_i)
  `HZP_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_i, busy_i)
  `HZP_ASSERT_NXT(a_done_single, clk_i, rst_ni, done_i, !done_i)
  `HZP_ASSERT_NOW(a_unf_zero, clk_i, rst_ni, unf_word, zone_out_i == 6'd0 && hits_i == 64'd0)
  `HZP_ASSERT_NOW(a_status_code, clk_i, rst_ni, done_i, status_known)

endmodule

bind hierarchical_zone_profiler_unit hzp_checker u_hzp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start),
  .busy_i     (busy),
  .done_i     (done_o),
  .status_i   (status_o),
  .zone_out_i (zone_out_o),
  .hits_i     (hits_o)
);

`default_nettype wire

// ----- sim/zone_profile_checker.sv -----
// Zone profiler checker: watches both channels, predicts each report word and compares it.
`default_nettype none

module zone_profile_checker
  import hzp_pkg::*;
#(
  parameter int unsigned ZONE_COUNT  = 64,
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        busy_i,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [5:0]  zone_i,
  input  wire logic [31:0] byte_count_i,
  input  wire logic [63:0] timestamp_i,
  input  wire logic        done_i,
  input  wire logic [1:0]  status_i,
  input  wire logic [5:0]  zone_out_i,
  input  wire logic [63:0] hits_i,
  input  wire logic [63:0] exclusive_ticks_i,
  input  wire logic [63:0] inclusive_ticks_i,
  input  wire logic [63:0] bytes_total_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o,
  output int unsigned      checked_o,
  output int unsigned      overflow_o,
  output int unsigned      underflow_o,
  output int unsigned      max_level_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] zone;
    row_t       row;
  } zone_report_t;

  row_t         zone_rows [ZONE_COUNT];
  logic [5:0]   open_zone [STACK_DEPTH];
  logic [5:0]   open_parent [STACK_DEPTH];
  logic [63:0]  open_incl [STACK_DEPTH];
  logic [63:0]  open_start [STACK_DEPTH];
  int unsigned  open_level;
  logic [5:0]   parent_zone;
  zone_report_t expected_reports [$];

  task automatic log_mismatch(input string label, input logic [63:0] want,
                              input logic [63:0] got);
    if (fail_count_o < 10)
      $display("%0t mismatch %s: expected %h got %h", $realtime, label, want, got);
    fail_count_o++;
  endtask

  task automatic compare_field(input string label, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) log_mismatch(label, want, got);
  endtask

  task automatic predict_report(input logic [1:0] cmd, input logic [5:0] zone_in,
                                input logic [31:0] bytes_in, input logic [63:0] stamp);
    logic [5:0]   z;
    logic [5:0]   p;
    logic [63:0]  elapsed;
    zone_report_t r;
    z = 6'(zone_in % ZONE_COUNT);
    r.status = STAT_OK;
    r.zone = z;
    case (cmd)
      CMD_BEGIN: begin
        if (open_level >= STACK_DEPTH) begin
          r.status = STAT_OVF;
          overflow_o++;
        end else begin
          open_zone[open_level] = z;
          open_parent[open_level] = parent_zone;
          open_incl[open_level] = zone_rows[z].incl;
          open_start[open_level] = stamp;
          zone_rows[z].bytes = zone_rows[z].bytes + 64'(bytes_in);
          parent_zone = z;
          open_level++;
          if (open_level > max_level_o) max_level_o = open_level;
        end
        r.row = zone_rows[z];
      end
      CMD_END: begin
        if (open_level == 0) begin
          r = '0;
          r.status = STAT_UNF;
          underflow_o++;
        end else begin
          open_level--;
          z = open_zone[open_level];
          p = open_parent[open_level];
          elapsed = stamp - open_start[open_level];
          parent_zone = p;
          zone_rows[p].excl = zone_rows[p].excl - elapsed;
          zone_rows[z].excl = zone_rows[z].excl + elapsed;
          zone_rows[z].incl = open_incl[open_level] + elapsed;
          zone_rows[z].hits = zone_rows[z].hits + 64'd1;
          r.zone = z;
          r.row = zone_rows[z];
        end
      end
      default: r.row = zone_rows[z];
    endcase
    expected_reports.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    zone_report_t want;
    if (!rst_ni) begin
      for (int i = 0; i < ZONE_COUNT; i++) zone_rows[i] = '0;
      open_level = 0;
      parent_zone = '0;
      expected_reports.delete();
      fail_count_o = 0;
      pending_o = 0;
      checked_o = 0;
      overflow_o = 0;
      underflow_o = 0;
      max_level_o = 0;
    end else begin
      if (done_i) begin
        if (expected_reports.size() == 0) begin
          log_mismatch("report word with none expected", '0, 64'(status_i));
        end else begin
          want = expected_reports.pop_front();
          compare_field("status", 64'(want.status), 64'(status_i));
          compare_field("zone_out", 64'(want.zone), 64'(zone_out_i));
          compare_field("hits", want.row.hits, hits_i);
          compare_field("exclusive_ticks", want.row.excl, exclusive_ticks_i);
          compare_field("inclusive_ticks", want.row.incl, inclusive_ticks_i);
          compare_field("bytes_total", want.row.bytes, bytes_total_i);
          checked_o++;
        end
      end
      if (start_i && !busy_i) predict_report(cmd_i, zone_i, byte_count_i, timestamp_i);
      pending_o = expected_reports.size();
    end
  end

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Testbench top for the zone profiler: clock, reset, command stimulus and verdict.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hzp_pkg::*;

  localparam int unsigned ZONE_COUNT  = 64;
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned WORD_TARGET = 1300;
  localparam logic [1:0]  CMD_SPARE   = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  cmd_i;
  logic [5:0]  zone_i;
  logic [31:0] byte_count_i;
  logic [63:0] timestamp_i;
  logic        done_o;
  logic [1:0]  status_o;
  logic [5:0]  zone_out_o;
  logic [63:0] hits_o;
  logic [63:0] exclusive_ticks_o;
  logic [63:0] inclusive_ticks_o;
  logic [63:0] bytes_total_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned overflows;
  int unsigned underflows;
  int unsigned max_level;

  hierarchical_zone_profiler_unit #(
    .ZONE_COUNT (ZONE_COUNT),
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .cmd_i,
    .zone_i,
    .byte_count_i,
    .timestamp_i,
    .done_o,
    .status_o,
    .zone_out_o,
    .hits_o,
    .exclusive_ticks_o,
    .inclusive_ticks_o,
    .bytes_total_o
  );

  zone_profile_checker #(
    .ZONE_COUNT (ZONE_COUNT),
    .STACK_DEPTH(STACK_DEPTH)
  ) i_checker (
    .clk_i,
    .rst_ni,
    .start_i          (start),
    .busy_i           (busy),
    .cmd_i,
    .zone_i,
    .byte_count_i,
    .timestamp_i,
    .done_i           (done_o),
    .status_i         (status_o),
    .zone_out_i       (zone_out_o),
    .hits_i           (hits_o),
    .exclusive_ticks_i(exclusive_ticks_o),
    .inclusive_ticks_i(inclusive_ticks_o),
    .bytes_total_i    (bytes_total_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked),
    .overflow_o       (overflows),
    .underflow_o      (underflows),
    .max_level_o      (max_level)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(input logic [1:0] cmd, input logic [5:0] zone,
                           input logic [31:0] bytes, input logic [63:0] stamp);
    start <= 1'b1;
    cmd_i <= cmd;
    zone_i <= zone;
    byte_count_i <= bytes;
    timestamp_i <= stamp;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    int unsigned pick;
    int unsigned begin_pct;
    bit          dive;
    logic [1:0]  cmd;
    logic [5:0]  zone;
    logic [31:0] bytes;
    logic [63:0] ts_now;

    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = CMD_READ;
    zone_i = '0;
    byte_count_i = '0;
    timestamp_i = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty stack end, reads, spare command, extremes, recursion, root parent
    send_word(CMD_END, 6'd9, 32'h0, 64'd0);
    send_word(CMD_READ, 6'd63, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(CMD_SPARE, 6'h2A, 32'h0, 64'd0);
    send_word(CMD_BEGIN, 6'd0, 32'hFFFF_FFFF, 64'd0);
    send_word(CMD_BEGIN, 6'd63, 32'h0, 64'd10);
    send_word(CMD_BEGIN, 6'd5, 32'h1, 64'd20);
    send_word(CMD_BEGIN, 6'd5, 32'hFFFF_FFFF, 64'd30);
    send_word(CMD_END, 6'd0, 32'h0, 64'd45);
    send_word(CMD_END, 6'd63, 32'h0, 64'd70);
    send_word(CMD_END, 6'd0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    // fill the stack near the top of the counter range, overflow, then a wrapping end
    for (int i = 1; i < STACK_DEPTH; i++)
      send_word(CMD_BEGIN, 6'(i * 4 + 1), $urandom, 64'hFFFF_FFFF_FFFF_FF00 + 64'(i));
    send_word(CMD_BEGIN, 6'd7, 32'h1234_5678, 64'hFFFF_FFFF_FFFF_FFF0);
    send_word(CMD_END, 6'd0, 32'h0, 64'd5);

    sent = 0;
    dive = 1'b0;
    ts_now = 64'd100;
    while (sent < WORD_TARGET) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        if ($urandom_range(0, 39) == 0) dive = !dive;
        begin_pct = dive ? 60 : 38;
        pick = $urandom_range(0, 99);
        if (pick < begin_pct) cmd = CMD_BEGIN;
        else if (pick < begin_pct + 34) cmd = CMD_END;
        else if (pick < 97) cmd = CMD_READ;
        else cmd = CMD_SPARE;
        zone = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 7))
                                           : 6'($urandom_range(0, 63));
        case ($urandom_range(0, 7))
          0: bytes = '0;
          1: bytes = '1;
          default: bytes = $urandom;
        endcase
        if ($urandom_range(0, 15) == 0) ts_now = {$urandom, $urandom};
        else ts_now = ts_now + 64'($urandom_range(0, 3000));
        send_word(cmd, zone, bytes, ts_now);
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end

    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("checked %0d report words; %0d overflowed begins, %0d underflowed ends",
             checked, overflows, underflows);
    $display("deepest nesting %0d of %0d, mismatches %0d", max_level, STACK_DEPTH,
             fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
